FILE: hdl/pwd_pkg.sv
package pwd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_VARINT  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_TRUNC_VARINT  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW      = 3'd2;
  localparam logic [2:0] ERR_FIELD_ZERO    = 3'd3;
  localparam logic [2:0] ERR_BAD_WIRE_TYPE = 3'd4;
  localparam logic [2:0] ERR_TRUNC_PAYLOAD = 3'd5;

  // Wire types handled
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_LEN    = 3'd2;

  // Tenth byte of a varint sits at bit 63
  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One classified message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       eom;
    logic       cont;     // continuation bit of a varint byte
    logic       hi_nz;    // any of bits 7..1 set (tenth-byte overflow check)
  } pwd_word_t;

endpackage

FILE: hdl/protobuf_wire_field_decoder.sv
// Streaming protobuf wire-format field decoder.
// Input channel: one message byte per word (in_data_byte) with
// in_end_of_message marking the last byte; accepted when in_valid is high
// and in_stall low. Output channel: at most one result word per byte
// (kind, field number, value, payload_last, error code, message_end),
// taken when out_valid is high and out_stall low.
// Structure: a front stage classifies each byte (continuation bit, overflow
// bits) into a small queue; the back stage runs the tag/value/length/payload
// state machine, one queued byte per cycle unless stalled, into an output register.
// Path: an accepted byte is written into the queue, then its result into the output register.
// Throughput: one byte per cycle sustained while the output is not stalled,
// set by the back state machine retiring one queued byte per cycle.
// On an error one error word is sent and later bytes are dropped until the
// end of the message; the consumer drops that message's earlier results.
// Receiver stall: the output register holds its word, the back stage stops
// popping, the queue fills and in_stall rises once it is full.
// Reset (rst_n low, synchronous): queue empty, output empty, decoder idle
// waiting for a tag.
module protobuf_wire_field_decoder #(
  parameter int QUEUE_DEPTH = pwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_field_number,
  output logic [63:0] out_value,
  output logic        out_payload_last,
  output logic [2:0]  out_error_code,
  output logic        out_message_end
);
  import pwd_pkg::*;

  pwd_word_t push_word;
  pwd_word_t head_word;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      head_valid;

  // byte classification and input handshake
  pwd_front u_front (
    .in_valid          (in_valid),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .q_full            (q_full),
    .push              (push),
    .push_word         (push_word)
  );

  // decouples input acceptance from output stalls
  pwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  // wire-format state machine and result register
  pwd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_word        (head_word),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_field_number (out_field_number),
    .out_value        (out_value),
    .out_payload_last (out_payload_last),
    .out_error_code   (out_error_code),
    .out_message_end  (out_message_end)
  );

endmodule

FILE: hdl/pwd_front.sv
module pwd_front (
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_message,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output pwd_pkg::pwd_word_t push_word
);
  import pwd_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_word.data_byte = in_data_byte;
    push_word.eom       = in_end_of_message;
    push_word.cont      = in_data_byte[7];
    push_word.hi_nz     = |in_data_byte[7:1];
  end

endmodule

FILE: hdl/pwd_queue.sv
module pwd_queue #(
  parameter int DEPTH = pwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pwd_pkg::pwd_word_t push_word,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output pwd_pkg::pwd_word_t head_word
);
  import pwd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pwd_word_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_word  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

FILE: hdl/pwd_back.sv
module pwd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  pwd_pkg::pwd_word_t head_word,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [31:0]        out_field_number,
  output logic [63:0]        out_value,
  output logic               out_payload_last,
  output logic [2:0]         out_error_code,
  output logic               out_message_end
);
  import pwd_pkg::*;

  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_VALUE   = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DRAIN   = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] field_r, field_nxt;
  logic [63:0] rem_r, rem_nxt;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_field_r;
  logic [63:0] out_value_r;
  logic        out_last_r;
  logic [2:0]  out_err_r;
  logic        out_end_r;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [31:0] res_field;
  logic [63:0] res_value;
  logic        res_last;
  logic [2:0]  res_err;
  logic        do_fail;
  logic [2:0]  fail_code;
  logic [5:0]  shamt;
  logic [63:0] acc_new;
  logic [31:0] tag_num;
  logic        last_idx;
  logic        eom;

  assign pop      = head_valid && (!out_valid_r || !out_stall);
  assign eom      = head_word.eom;
  assign last_idx = (idx_r == VARINT_LAST_IDX);
  assign shamt    = 6'({2'b00, idx_r} * 6'd7);
  assign acc_new  = acc_r | ({57'b0, head_word.data_byte[6:0]} << shamt);
  assign tag_num  = acc_new[34:3];

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    field_nxt = field_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res_kind  = KIND_VARINT;
    res_field = field_r;
    res_value = '0;
    res_last  = 1'b0;
    res_err   = ERR_NONE;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    if (pop) begin
      unique case (phase_r)
        PH_DRAIN: begin
          if (eom) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_PAYLOAD: begin
          if (rem_r[63:1] == '0) begin
            res_valid = 1'b1;
            res_kind  = KIND_PAYLOAD;
            res_value = {56'b0, head_word.data_byte};
            res_last  = 1'b1;
            rem_nxt   = '0;
            phase_nxt = PH_TAG;
          end else if (eom) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNC_PAYLOAD;
          end else begin
            res_valid = 1'b1;
            res_kind  = KIND_PAYLOAD;
            res_value = {56'b0, head_word.data_byte};
            rem_nxt   = rem_r - 64'd1;
          end
        end
        PH_TAG, PH_VALUE, PH_LENGTH: begin
          if (last_idx && head_word.hi_nz) begin
            do_fail   = 1'b1;
            fail_code = ERR_OVERFLOW;
          end else if (head_word.cont && !last_idx) begin
            acc_nxt = acc_new;
            idx_nxt = idx_r + 4'd1;
            if (eom) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNC_VARINT;
            end
          end else begin
            // varint complete
            acc_nxt = '0;
            idx_nxt = '0;
            if (phase_r == PH_TAG) begin
              if (tag_num == '0) begin
                do_fail   = 1'b1;
                fail_code = ERR_FIELD_ZERO;
              end else if (acc_new[2:0] == WIRE_VARINT || acc_new[2:0] == WIRE_LEN) begin
                phase_nxt = (acc_new[2:0] == WIRE_VARINT) ? PH_VALUE : PH_LENGTH;
                field_nxt = tag_num;
                if (eom) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_TRUNC_VARINT;
                end
              end else begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_WIRE_TYPE;
              end
            end else if (phase_r == PH_VALUE) begin
              res_valid = 1'b1;
              res_kind  = KIND_VARINT;
              res_value = acc_new;
              phase_nxt = PH_TAG;
            end else if (acc_new == '0) begin
              res_valid = 1'b1;
              res_kind  = KIND_EMPTY;
              phase_nxt = PH_TAG;
            end else if (eom) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNC_PAYLOAD;
            end else begin
              rem_nxt   = acc_new;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        default: begin
          phase_nxt = PH_TAG;
        end
      endcase
    end
    if (do_fail) begin
      res_valid = 1'b1;
      res_kind  = KIND_ERROR;
      res_field = '0;
      res_value = '0;
      res_last  = 1'b0;
      res_err   = fail_code;
      acc_nxt   = '0;
      idx_nxt   = '0;
      rem_nxt   = '0;
      phase_nxt = eom ? PH_TAG : PH_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG;
      acc_r       <= '0;
      idx_r       <= '0;
      field_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
      field_r <= field_nxt;
      rem_r   <= rem_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind_r  <= res_kind;
      out_field_r <= res_field;
      out_value_r <= res_value;
      out_last_r  <= res_last;
      out_err_r   <= res_err;
      out_end_r   <= eom;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_field_number = out_field_r;
  assign out_value        = out_value_r;
  assign out_payload_last = out_last_r;
  assign out_error_code   = out_err_r;
  assign out_message_end  = out_end_r;

endmodule

FILE: hdl/pwd_checker.sv
module pwd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [31:0] out_field_number,
  input logic [63:0] out_value,
  input logic        out_payload_last,
  input logic [2:0]  out_error_code,
  input logic        out_message_end
);
  import pwd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_value)
      && $stable(out_field_number) && $stable(out_error_code))
    else $error("stalled result word changed");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |->
      out_field_number == '0 && out_value == '0 && out_error_code != ERR_NONE)
    else $error("malformed error word");

  a_ok_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERROR |->
      out_error_code == ERR_NONE && out_field_number != '0)
    else $error("good word with error code or field zero");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_last |-> out_kind == KIND_PAYLOAD)
    else $error("payload_last on non-payload word");

endmodule

bind protobuf_wire_field_decoder pwd_checker u_pwd_checker (.*);
